>>> rtl/sms_pkg.sv
`timescale 1ns / 1ps
package sms_pkg;

  // Field and accumulator widths, sized for the longest run of 127 samples.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned SQ_W     = 38;
  localparam int unsigned SIGMA_W  = 16;

  // Entries in the queue between the accumulator and the arithmetic back end.
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // One finished run, as handed from the front end to the back end.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
    logic [CNT_W-1:0]        cnt;
  } job_t;

  // Fill status of the run queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/sms_front.sv
`timescale 1ns / 1ps
module sms_front import sms_pkg::*; #(
  parameter int unsigned MAX_RUN = 127
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  output logic                       push_o,
  output job_t                       job_o
);

  logic signed [SUM_W-1:0]      sum_q, sum_d;
  logic [SQ_W-1:0]              sq_q, sq_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic signed [2*SAMPLE_W-1:0] square;
  logic signed [SUM_W-1:0]      sum_n;
  logic [SQ_W-1:0]              sq_n;
  logic [CNT_W-1:0]             cnt_n;
  logic                         close;

  assign square = sample_i * sample_i;
  assign sum_n  = sum_q + SUM_W'(sample_i);
  assign sq_n   = sq_q + SQ_W'($unsigned(square));
  assign cnt_n  = cnt_q + 1'b1;
  // A run ends on the marked sample or when it reaches the longest allowed length.
  assign close  = last_i || (cnt_n == CNT_W'(MAX_RUN));

  always_comb begin
    sum_d = sum_q;
    sq_d  = sq_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (close) begin
        sum_d = '0;
        sq_d  = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_n;
        sq_d  = sq_n;
        cnt_d = cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      sq_q  <= sq_d;
      cnt_q <= cnt_d;
    end
  end

  assign push_o    = accept_i && close;
  assign job_o.sum = sum_n;
  assign job_o.sq  = sq_n;
  assign job_o.cnt = cnt_n;

endmodule

>>> rtl/sms_queue.sv
`timescale 1ns / 1ps
module sms_queue import sms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);

  job_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] fill_q, fill_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (fill_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = entry_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      fill_q <= fill_d;
    end
  end

  // A run must never be offered while the queue has no room for it.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("run pushed into a full queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

>>> rtl/sms_back.sv
`timescale 1ns / 1ps
module sms_back import sms_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  q_stat_t                    q_stat_i,
  input  job_t                       job_i,
  output logic                       pop_o,
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] mean_o,
  output logic [SIGMA_W-1:0]         sigma_o,
  output logic                       too_few_o
);

  localparam int unsigned MEAN_W = SAMPLE_W + 1;
  localparam int unsigned DCNT_W = $clog2(SUM_W);
  localparam int unsigned P1_W   = MEAN_W + SUM_W;
  localparam int unsigned P2_W   = 2 * MEAN_W;
  localparam int unsigned P3_W   = P2_W + CNT_W + 1;
  localparam int unsigned VW     = SQ_W + 5;
  localparam int unsigned VS_W   = SQ_W + 2;
  localparam int unsigned CMP_W  = VS_W + 2;
  localparam int unsigned D_W    = SIGMA_W + 1;
  localparam int unsigned DSQ_W  = 2 * D_W;
  localparam int unsigned PR_W   = DSQ_W + CNT_W;
  localparam int unsigned SB_W   = $clog2(SIGMA_W);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_MUL1 = 8'b0000_0100,
    ST_MUL2 = 8'b0000_1000,
    ST_VAR  = 8'b0001_0000,
    ST_SQA  = 8'b0010_0000,
    ST_SQB  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  state_e                    state_q, state_d;
  logic signed [SUM_W-1:0]   s_q;
  logic [SQ_W-1:0]           q_q;
  logic [CNT_W-1:0]          n_q;
  logic                      neg_q, few_q;
  logic [SUM_W-1:0]          dvd_q;
  logic [CNT_W-1:0]          rem_q;
  logic [DCNT_W-1:0]         dcnt_q;
  logic signed [MEAN_W-1:0]  m_q;
  logic signed [P1_W-1:0]    p1_q;
  logic signed [P2_W-1:0]    p2_q;
  logic signed [P3_W-1:0]    p3_q;
  logic [VS_W-1:0]           v_q;
  logic [DSQ_W-1:0]          dsq_q;
  logic [SIGMA_W-1:0]        k_q;
  logic [SB_W-1:0]           sb_q;

  logic [SUM_W-1:0]          mag;
  logic [CNT_W:0]            rem_sh;
  logic                      ge;
  logic [MEAN_W-1:0]         quo;
  logic signed [VW-1:0]      q_ext, p1_ext, p3_ext, vs_w;
  logic [SIGMA_W-1:0]        trial;
  logic [D_W-1:0]            d_odd;
  logic [CNT_W-1:0]          nm1;
  logic [PR_W-1:0]           prod;
  logic                      fits;

  // Magnitude of the run sum; half the count is added when the run is loaded, for rounded division.
  assign mag    = job_i.sum[SUM_W-1] ? SUM_W'(-job_i.sum) : $unsigned(job_i.sum);

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, n_q};
  assign quo    = dvd_q[MEAN_W-1:0];

  // Sum of squared deviations: Q - 2 m S + n m^2.
  assign q_ext  = VW'(q_q);
  assign p1_ext = VW'(p1_q);
  assign p3_ext = VW'(p3_q);
  assign vs_w   = q_ext - (p1_ext <<< 1) + p3_ext;

  // Square root search: keep the trial bit when (2k-1)^2 (n-1) <= 4 V.
  assign trial  = k_q | (SIGMA_W'(1) << sb_q);
  assign d_odd  = {trial, 1'b0} - D_W'(1);
  assign nm1    = n_q - 1'b1;
  assign prod   = dsq_q * nm1;
  assign fits   = CMP_W'(prod) <= {v_q, 2'b00};

  assign pop_o  = (state_q == ST_IDLE) && !q_stat_i.empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_q == '0) begin
          state_d = few_q ? ST_EMIT : ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_VAR;
      ST_VAR:  state_d = ST_SQA;
      ST_SQA:  state_d = ST_SQB;
      ST_SQB:  state_d = (sb_q == '0) ? ST_EMIT : ST_SQA;
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          s_q    <= job_i.sum;
          q_q    <= job_i.sq;
          n_q    <= job_i.cnt;
          neg_q  <= job_i.sum[SUM_W-1];
          few_q  <= job_i.cnt < CNT_W'(2);
          dvd_q  <= mag + SUM_W'(job_i.cnt >> 1);
          rem_q  <= '0;
          dcnt_q <= DCNT_W'(SUM_W - 1);
          k_q    <= '0;
          sb_q   <= SB_W'(SIGMA_W - 1);
        end
      end
      ST_DIV: begin
        rem_q  <= ge ? CNT_W'(rem_sh - {1'b0, n_q}) : rem_sh[CNT_W-1:0];
        dvd_q  <= {dvd_q[SUM_W-2:0], ge};
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          // The last quotient bit lands here, so finish the mean from it.
          m_q <= neg_q ? -$signed({quo[MEAN_W-2:0], ge}) : $signed({quo[MEAN_W-2:0], ge});
        end
      end
      ST_MUL1: begin
        p1_q <= m_q * s_q;
        p2_q <= m_q * m_q;
      end
      ST_MUL2: begin
        p3_q <= p2_q * $signed({1'b0, n_q});
      end
      ST_VAR: begin
        v_q <= vs_w[VW-1] ? '0 : vs_w[VS_W-1:0];
      end
      ST_SQA: begin
        dsq_q <= d_odd * d_odd;
      end
      ST_SQB: begin
        if (fits) begin
          k_q <= trial;
        end
        sb_q <= sb_q - 1'b1;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign valid_o   = (state_q == ST_EMIT);
  assign mean_o    = m_q[SAMPLE_W-1:0];
  assign sigma_o   = k_q;
  assign too_few_o = few_q;

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  a_few_zero_sigma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && too_few_o) |-> (sigma_o == '0))
    else $error("short run reported a nonzero sigma");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < n_q))
    else $error("division remainder not below the count");

endmodule

>>> rtl/sample_mean_and_sigma.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// samples   in         start_i, busy_o           sample_i, last_i
// results   out        valid_o (one-cycle pulse) mean_o, sigma_o, too_few_o
//
// A sample is taken at every rising edge with start_i high and busy_o low, so
// samples stream in at one per cycle. The sample that ends a run (last_i, or the
// MAX_RUN-th sample) hands the run totals to a two-entry queue. The back end
// divides bit-serially for the mean; runs of two or more samples then go through
// multiply-add steps and a square and compare step per bit of the 16-bit root.
// busy_o rises only while both queue entries hold finished runs.
// Reset is asynchronous and active low; it clears the totals, the queue and the
// back end sequencer. The receiver cannot stall, so each result is a single
// cycle pulse on valid_o.
module sample_mean_and_sigma import sms_pkg::*; #(
  parameter int unsigned MAX_RUN = 127
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] mean_o,
  output logic [SIGMA_W-1:0]         sigma_o,
  output logic                       too_few_o
);

  logic    accept;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;

  // The front end can always take a sample unless a closing sample could find the
  // queue full.
  assign busy_o = q_stat.full;
  assign accept = start_i && !busy_o;

  // Front end: keeps count, sum and sum of squares for the open run.
  sms_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .sample_i(sample_i),
    .last_i  (last_i),
    .push_o  (push),
    .job_o   (push_job)
  );

  // Finished runs wait here while the back end works on an earlier one.
  sms_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .job_i (push_job),
    .pop_i (pop),
    .job_o (head_job),
    .stat_o(q_stat)
  );

  // Back end: rounded mean, variance from exact sums, and integer square root.
  sms_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .job_i    (head_job),
    .pop_o    (pop),
    .valid_o  (valid_o),
    .mean_o   (mean_o),
    .sigma_o  (sigma_o),
    .too_few_o(too_few_o)
  );

endmodule

>>> tb/sample_mean_and_sigma_tb.sv
`timescale 1ns / 1ps
module sample_mean_and_sigma_tb;
  import sms_pkg::*;

  // The longest run the block accepts before it closes the run by itself.
  localparam int unsigned MAX_RUN = 127;
  // Cycles with no sample taken and no result seen before the run is declared hung.
  // While runs are queued the back end keeps turning them out one after another,
  // so the longest quiet stretch is set by the sender's idling.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles to linger after the last result.
  localparam int unsigned TAIL_CYCLES = 200;
  // Random samples per idling phase.
  localparam int unsigned PHASE_ITEMS = 385;

  // How the samples of one random run are drawn.
  typedef enum {
    FULL_RANGE,
    RAIL,
    CLUSTER
  } sample_kind_e;

  // One sample item waiting for the driver. The idle percentage is the chance that
  // the driver leaves start low in a given cycle before it offers this item. With
  // drain set, the driver holds the item back until every pending result is out.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       fin;
    int unsigned                idle_pct;
    bit                         drain;
  } sample_item_t;

  // What the block should report at the end of one run.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic [SIGMA_W-1:0]         sigma;
    logic                       too_few;
  } run_stats_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       last_i = 1'b0;
  logic                       busy_o;
  logic                       valid_o;
  logic signed [SAMPLE_W-1:0] mean_o;
  logic [SIGMA_W-1:0]         sigma_o;
  logic                       too_few_o;

  sample_item_t pending_samples[$];
  run_stats_t   expected_stats[$];

  // Runs closed by the predictor and results taken by the monitor. Both are
  // updated with nonblocking assignments so that every block sees the values
  // from before the current edge.
  int unsigned runs_closed = 0;
  int unsigned runs_reported = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  // Running totals of the open run, kept wide enough that they never wrap.
  longint      run_sum = 0;
  longint      run_square_sum = 0;
  int unsigned run_count = 0;

  sample_mean_and_sigma #(
    .MAX_RUN(MAX_RUN)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .sample_i (sample_i),
    .last_i   (last_i),
    .valid_o  (valid_o),
    .mean_o   (mean_o),
    .sigma_o  (sigma_o),
    .too_few_o(too_few_o)
  );

  always #2 clk_i = ~clk_i;

  // Adds one sample to the open run. When the sample closes the run, either by its
  // last flag or by being the MAX_RUN-th sample, the function fills in the
  // statistics, clears the totals and returns 1.
  function automatic bit accumulate_sample(input logic signed [SAMPLE_W-1:0] x,
                                           input logic fin, output run_stats_t stats);
    longint             v;
    longint             n;
    longint             mag;
    longint             m;
    longint             dev_sq;
    longint             four_v;
    longint             d;
    logic [SIGMA_W-1:0] root;
    logic [SIGMA_W-1:0] trial;
    v = longint'(x);
    run_sum += v;
    run_square_sum += v * v;
    run_count++;
    stats = '0;
    if (!fin && run_count < MAX_RUN) begin
      return 1'b0;
    end
    n = longint'(run_count);
    // The mean is rounded half away from zero, so the magnitude is rounded and
    // the sign put back afterwards.
    mag = (run_sum < 0) ? -run_sum : run_sum;
    m = (mag + n / 2) / n;
    if (run_sum < 0) begin
      m = -m;
    end
    root = '0;
    if (n >= 2) begin
      // The squared deviations about the rounded mean, from the exact totals.
      dev_sq = run_square_sum - 2 * m * run_sum + n * m * m;
      if (dev_sq < 0) begin
        dev_sq = 0;
      end
      // Sigma is the largest k with (2k - 1)^2 * (n - 1) <= 4 * dev_sq, which is
      // the square root of the variance rounded to nearest, built one bit at a time.
      four_v = 4 * dev_sq;
      for (int b = SIGMA_W - 1; b >= 0; b--) begin
        trial = root | (SIGMA_W'(1) << b);
        d = 2 * longint'(trial) - 1;
        if (d * d * (n - 1) <= four_v) begin
          root = trial;
        end
      end
    end
    stats.mean = m[SAMPLE_W-1:0];
    stats.sigma = root;
    stats.too_few = (n < 2);
    run_sum = 0;
    run_square_sum = 0;
    run_count = 0;
    return 1'b1;
  endfunction

  // Draws one sample: anywhere in the range, on one of the two rails, or within a
  // spread around a center, clipped to the range.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input sample_kind_e kind,
                                                             input int centre,
                                                             input int spread);
    int v;
    case (kind)
      FULL_RANGE: begin
        v = int'($urandom_range(65535)) - 32768;
      end
      RAIL: begin
        v = $urandom_range(1) ? 32767 : -32768;
      end
      default: begin
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767) begin
          v = 32767;
        end
        if (v < -32768) begin
          v = -32768;
        end
      end
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x, input logic fin,
                             input int unsigned idle_pct, input bit drain);
    sample_item_t item;
    item.sample = x;
    item.fin = fin;
    item.idle_pct = idle_pct;
    item.drain = drain;
    pending_samples.push_back(item);
  endtask

  // Queues one random run of len samples. Most runs keep their samples in a
  // cluster so that sigma spans small and large values; a few samples in a
  // cluster run are drawn from the whole range as outliers. A run of MAX_RUN
  // samples ends with last set or clear at random, since the block closes it
  // either way.
  task automatic push_run(input int unsigned len, input int unsigned idle_pct,
                          input bit drain);
    sample_kind_e kind;
    sample_kind_e this_kind;
    int           centre;
    int           spread;
    int unsigned  pick;
    logic         fin;
    pick = $urandom_range(99);
    kind = (pick < 25) ? FULL_RANGE : (pick < 40) ? RAIL : CLUSTER;
    centre = int'($urandom_range(65535)) - 32768;
    spread = (1 << $urandom_range(15)) - 1;
    for (int unsigned i = 0; i < len; i++) begin
      this_kind = (kind == CLUSTER && $urandom_range(9) == 0) ? FULL_RANGE : kind;
      if (i + 1 < len) begin
        fin = 1'b0;
      end else if (len == MAX_RUN) begin
        fin = 1'($urandom_range(1));
      end else begin
        fin = 1'b1;
      end
      push_sample(draw_sample(this_kind, centre, spread), fin, idle_pct, drain && i == 0);
    end
  endtask

  // Driver. At each rising edge it first notes whether the item on the ports was
  // taken, feeding it to the predictor, and then decides what to offer next. An
  // item that meets busy stays on the ports unchanged. While start is low the
  // payload ports carry random values, which the block has to ignore.
  always @(posedge clk_i) begin : driver
    run_stats_t  stats;
    int unsigned closed_now;
    closed_now = runs_closed;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (accumulate_sample(sample_i, last_i, stats)) begin
          expected_stats.push_back(stats);
          closed_now++;
        end
        void'(pending_samples.pop_front());
        runs_closed <= closed_now;
      end
      if (start_i && busy_o) begin
        // Hold the current item until the block takes it.
      end else if (pending_samples.size() != 0 &&
                   !(pending_samples[0].drain && closed_now != runs_reported) &&
                   $urandom_range(99) >= pending_samples[0].idle_pct) begin
        start_i <= 1'b1;
        sample_i <= pending_samples[0].sample;
        last_i <= pending_samples[0].fin;
      end else begin
        start_i <= 1'b0;
        sample_i <= SAMPLE_W'($urandom_range(65535));
        last_i <= 1'($urandom_range(1));
      end
    end
  end

  // Monitor. A result pulse is checked against the oldest run that the predictor
  // has closed; a pulse with no closed run waiting is a failure of its own.
  always @(posedge clk_i) begin : monitor
    run_stats_t want;
    if (rst_ni && valid_o) begin
      runs_reported <= runs_reported + 1;
      if (runs_reported >= runs_closed) begin
        $display("%0t: result with no run closed, got mean %0d sigma %0d too_few %0d",
                 $time, mean_o, sigma_o, too_few_o);
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (mean_o !== want.mean) begin
          $display("%0t: mean mismatch, expected %0d, got %0d", $time, want.mean, mean_o);
          errors++;
        end
        if (sigma_o !== want.sigma) begin
          $display("%0t: sigma mismatch, expected %0d, got %0d", $time, want.sigma,
                   sigma_o);
          errors++;
        end
        if (too_few_o !== want.too_few) begin
          $display("%0t: too_few mismatch, expected %0d, got %0d", $time, want.too_few,
                   too_few_o);
          errors++;
        end
      end
    end
  end

  // Watchdog. Any cycle in which a sample is taken or a result appears counts as
  // progress; a long stretch without either means the block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned idle_pcts[4];
    int          directed_vals[19];
    logic        directed_last[19];
    int unsigned phase_items;
    int unsigned len;
    int unsigned pick;
    // Sender idling per phase: none, heavy, none again, light. The receiver cannot
    // stall, so phases that would stall it run with the sender's setting alone.
    idle_pcts = '{0, 55, 0, 29};
    // Directed runs: single-sample runs at both rails and at zero, which flag too
    // few samples; pairs at the rails, including the widest possible spread and
    // equal samples with sigma zero; mean ties that round away from zero on
    // either side; and short runs with a small and a very large deviation.
    directed_vals = '{-32768, 32767, 0,
                      -32768, 32767, 32767, 32767, -32768, -32768,
                      1, 2, -1, -2,
                      0, 0, 1, -32768, 32767, -32768};
    directed_last = '{1'b1, 1'b1, 1'b1,
                      1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                      1'b0, 1'b1, 1'b0, 1'b1,
                      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    for (int i = 0; i < 19; i++) begin
      push_sample(directed_vals[i][SAMPLE_W-1:0], directed_last[i], 0, 1'b0);
    end
    // Two runs of full length, so the block has to close a run on its own count.
    push_run(MAX_RUN, 0, 1'b0);
    push_run(MAX_RUN, 0, 1'b0);
    for (int p = 0; p < 4; p++) begin
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          len = 1;
        end else if (pick < 20) begin
          len = 2;
        end else if (pick < 75) begin
          len = $urandom_range(16, 3);
        end else if (pick < 93) begin
          len = $urandom_range(64, 17);
        end else begin
          len = MAX_RUN;
        end
        // Each later phase opens by waiting for the block to drain completely.
        push_run(len, idle_pcts[p], p > 0 && phase_items == 0);
        phase_items += len;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampling on the falling edge keeps these checks clear of the rising edge.
    while (pending_samples.size() != 0 || start_i) @(negedge clk_i);
    while (runs_reported != runs_closed) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
